[rtl/enclosed_region_flood_fill_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the enclosed-region flood fill core
// Sampled on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ENCLOSED_REGION_FLOOD_FILL_CORE_MACROS_SVH
`define ENCLOSED_REGION_FLOOD_FILL_CORE_MACROS_SVH

// Same-cycle implication
`define ERFF_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ERFF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/erff_pkg.sv]
// ----------------------------------------------------------------------------
// erff_pkg
// Shared widths, reset values and the per-cell control struct.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package erff_pkg;

    localparam int GRID_W       = 32;   // columns per row, fixed
    localparam int SIZE_W       = 6;    // grid size register width
    localparam int ROW_NUM_W    = 5;    // result row index width
    localparam int MAX_SIZE_DEF = 32;   // default number of row cells
    localparam int OUT_DATA_W   = 72;   // 5 + 32 + 32 bits padded to bytes

    localparam logic [SIZE_W-1:0] GRID_SIZE_RST = 6'd32;

    // Per-cell control, driven by the sequencer in the top level
    typedef struct packed {
        logic wr;         // store the incoming row in this cell
        logic seed;       // load the border seed of the flood
        logic step;       // one flood propagation step
        logic shift;      // take wall and reached rows from the cell below
        logic active;     // cell lies inside the grid
        logic edge_row;   // cell is the first or last row of the grid
        logic has_below;  // the cell below lies inside the grid
    } cell_ctl_t;

endpackage

[rtl/erff_cell.sv]
// ----------------------------------------------------------------------------
// erff_cell
// One grid row: holds the wall mask and the reached mask, steps the flood
// from its own bits and its neighbors' reached rows, and shifts toward row 0
// while results are sent.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module erff_cell
    import erff_pkg::*;
(
    input  logic              clk,
    input  cell_ctl_t         ctl,
    input  logic [GRID_W-1:0] row_in,
    input  logic [GRID_W-1:0] cols,
    input  logic [GRID_W-1:0] edge_mask,
    input  logic [GRID_W-1:0] above_reached,
    input  logic [GRID_W-1:0] below_reached,
    input  logic [GRID_W-1:0] below_wall,
    output logic [GRID_W-1:0] wall,
    output logic [GRID_W-1:0] reached,
    output logic              changed
);

    logic [GRID_W-1:0] wall_reg;
    logic [GRID_W-1:0] wall_next;
    logic [GRID_W-1:0] reached_reg;
    logic [GRID_W-1:0] reached_next;
    logic [GRID_W-1:0] open_bits;
    logic [GRID_W-1:0] spread;
    logic [GRID_W-1:0] seed_bits;

    // Open cells of this row inside the grid columns
    assign open_bits = ~wall_reg & cols;

    // Grow by one cell horizontally and vertically
    always_comb
    begin
        spread = reached_reg | (reached_reg << 1) | (reached_reg >> 1) | above_reached;
        if (ctl.has_below)
        begin
            spread = spread | below_reached;
        end
        spread = spread & open_bits;
    end

    // Border seed: whole row on first and last rows, outer columns elsewhere
    assign seed_bits = (ctl.edge_row ? cols : edge_mask) & open_bits;

    assign changed = ctl.step && ctl.active && (spread != reached_reg);

    // Select next row contents
    always_comb
    begin
        wall_next    = wall_reg;
        reached_next = reached_reg;
        if (ctl.wr)
        begin
            wall_next = row_in & cols;
        end
        else if (ctl.shift)
        begin
            wall_next    = below_wall;
            reached_next = below_reached;
        end
        else if (ctl.seed)
        begin
            reached_next = ctl.active ? seed_bits : '0;
        end
        else if (ctl.step && ctl.active)
        begin
            reached_next = spread;
        end
    end

    always_ff @(posedge clk)
    begin
        wall_reg    <= wall_next;
        reached_reg <= reached_next;
    end

    assign wall    = wall_reg;
    assign reached = reached_reg;

endmodule

[rtl/enclosed_region_flood_fill_core.sv]
// ----------------------------------------------------------------------------
// enclosed_region_flood_fill_core
// 4-connected hole fill of a square binary grid held in a chain of row cells.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one grid row per item (s_axis_tdata, bit c set
//   for a wall at column c). cfg_wr_en/cfg_wr_data set the grid size (1..32,
//   0 acts as 1, larger values saturate) and restart the grid being loaded;
//   write it only while the core is idle.
//   Rows load one per cycle while s_axis_tvalid is high. After the last row
//   the core seeds the border, then runs flood propagation steps until a
//   step sees no change; how many steps depends on the grid contents. Each
//   step is one parallel update of every row cell from its neighbors.
//   The core then sends one result item per row, row 0 first, one per cycle
//   while m_axis_tready is high; tlast marks the final row. A stalled
//   receiver holds the current item and the row chain in place.
//   s_axis_tready is low from the last row until the final result is taken.
//   Reset clears the sequencer, the row count and sets the grid size to 32;
//   row contents are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "enclosed_region_flood_fill_core_macros.svh"

module enclosed_region_flood_fill_core
    import erff_pkg::*;
#(
    parameter int MAX_SIZE = MAX_SIZE_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration: grid size
    input  logic                  cfg_wr_en,
    input  logic [SIZE_W-1:0]     cfg_wr_data,
    // Input rows
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [GRID_W-1:0]     s_axis_tdata,   // [31:0] row_walls
    // Result rows
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [4:0] row_number,
                                                  // [36:5] wall_mask,
                                                  // [68:37] enclosed_mask,
                                                  // [71:69] zero
    output logic                  m_axis_tlast    // last_row
);

    localparam int NCELL = (MAX_SIZE < GRID_W) ? MAX_SIZE : GRID_W;
    localparam logic [SIZE_W-1:0] SIZE_LIM = SIZE_W'(NCELL);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SEED,
        ST_FLOOD,
        ST_EMIT
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    logic [SIZE_W-1:0]      grid_size_reg;
    logic [SIZE_W-1:0]      grid_size_next;
    logic [SIZE_W-1:0]      rows_loaded_reg;
    logic [SIZE_W-1:0]      rows_loaded_next;
    logic [ROW_NUM_W-1:0]   out_cnt_reg;
    logic [ROW_NUM_W-1:0]   out_cnt_next;

    logic [SIZE_W-1:0]      n_eff;
    logic [GRID_W-1:0]      cols;
    logic [GRID_W-1:0]      edge_mask;
    logic                   in_accept;
    logic                   out_accept;
    logic                   last_in;
    logic                   last_out;
    logic                   any_changed;

    cell_ctl_t              ctl [NCELL];
    logic [GRID_W-1:0]      wall_row    [NCELL];
    logic [GRID_W-1:0]      reached_row [NCELL];
    logic [NCELL-1:0]       changed;

    // Effective grid size and column masks
    always_comb
    begin
        if (grid_size_reg == '0)
        begin
            n_eff = SIZE_W'(1);
        end
        else if (grid_size_reg > SIZE_LIM)
        begin
            n_eff = SIZE_LIM;
        end
        else
        begin
            n_eff = grid_size_reg;
        end
    end

    assign cols      = ~({GRID_W{1'b1}} << n_eff);
    assign edge_mask = GRID_W'(1) | (GRID_W'(1) << (n_eff - SIZE_W'(1)));

    assign s_axis_tready = (state_reg == ST_LOAD);
    assign m_axis_tvalid = (state_reg == ST_EMIT);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_accept    = m_axis_tvalid && m_axis_tready;
    assign last_in       = (rows_loaded_reg == n_eff - SIZE_W'(1));
    assign last_out      = ({1'b0, out_cnt_reg} == n_eff - SIZE_W'(1));
    assign any_changed   = |changed;

    // Row cell chain
    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        logic [GRID_W-1:0] above_r;
        logic [GRID_W-1:0] below_r;
        logic [GRID_W-1:0] below_w;

        if (i == 0)
        begin : g_top
            assign above_r = '0;
        end
        else
        begin : g_mid
            assign above_r = reached_row[i-1];
        end

        if (i == NCELL - 1)
        begin : g_bot
            assign below_r = '0;
            assign below_w = '0;
        end
        else
        begin : g_inner
            assign below_r = reached_row[i+1];
            assign below_w = wall_row[i+1];
        end

        always_comb
        begin
            ctl[i].wr        = in_accept && (rows_loaded_reg == SIZE_W'(i));
            ctl[i].seed      = (state_reg == ST_SEED);
            ctl[i].step      = (state_reg == ST_FLOOD);
            ctl[i].shift     = out_accept;
            ctl[i].active    = (SIZE_W'(i) < n_eff);
            ctl[i].edge_row  = (i == 0) || (SIZE_W'(i) == n_eff - SIZE_W'(1));
            ctl[i].has_below = (SIZE_W'(i + 1) < n_eff);
        end

        erff_cell u_cell (
            .clk           (clk),
            .ctl           (ctl[i]),
            .row_in        (s_axis_tdata),
            .cols          (cols),
            .edge_mask     (edge_mask),
            .above_reached (above_r),
            .below_reached (below_r),
            .below_wall    (below_w),
            .wall          (wall_row[i]),
            .reached       (reached_row[i]),
            .changed       (changed[i])
        );
    end

    // Sequencer: load rows, seed, flood until stable, emit rows
    always_comb
    begin
        state_next       = state_reg;
        grid_size_next   = grid_size_reg;
        rows_loaded_next = rows_loaded_reg;
        out_cnt_next     = out_cnt_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (cfg_wr_en)
                begin
                    grid_size_next   = cfg_wr_data;
                    rows_loaded_next = '0;
                end
                else if (in_accept)
                begin
                    if (last_in)
                    begin
                        rows_loaded_next = '0;
                        state_next       = ST_SEED;
                    end
                    else
                    begin
                        rows_loaded_next = rows_loaded_reg + SIZE_W'(1);
                    end
                end
            end
            ST_SEED:
            begin
                state_next = ST_FLOOD;
            end
            ST_FLOOD:
            begin
                if (!any_changed)
                begin
                    out_cnt_next = '0;
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_accept)
                begin
                    out_cnt_next = out_cnt_reg + ROW_NUM_W'(1);
                    if (last_out)
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_LOAD;
            grid_size_reg   <= GRID_SIZE_RST;
            rows_loaded_reg <= '0;
            out_cnt_reg     <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            grid_size_reg   <= grid_size_next;
            rows_loaded_reg <= rows_loaded_next;
            out_cnt_reg     <= out_cnt_next;
        end
    end

    // Result item comes from the head of the chain
    assign m_axis_tdata = {3'b000,
                           ~(wall_row[0] | reached_row[0]) & cols,
                           wall_row[0],
                           out_cnt_reg};
    assign m_axis_tlast = last_out;

    // Checks
    `ERFF_ASSERT_IMPL(a_no_overlap, m_axis_tvalid, !s_axis_tready,
        "input taken while results pending")
    `ERFF_ASSERT_NEXT(a_fill_starts, in_accept && last_in, state_reg == ST_SEED,
        "fill did not start after last row")
    `ERFF_ASSERT_NEXT(a_emit_runs, out_accept && !m_axis_tlast, m_axis_tvalid,
        "result run broken before last row")
    `ERFF_ASSERT_NEXT(a_emit_ends, out_accept && m_axis_tlast, s_axis_tready,
        "core not ready after final result")

endmodule

[dv/tb_enclosed_region_flood_fill_core.sv]
// ----------------------------------------------------------------------------
// tb_enclosed_region_flood_fill_core
// Streams square grids of wall rows into the hole fill core at many grid
// sizes. A scoreboard keeps its own copy of the rows, floods each finished
// grid from the border and checks every result row field by field. Both
// stream sides idle in random bursts, and the receiver once holds off long
// enough to back the core up into its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_enclosed_region_flood_fill_core;
    import erff_pkg::*;

    localparam int RANDOM_ROWS  = 270;
    localparam int QUIET_AFTER  = 220;    // random rows before idling stops
    localparam int LONG_HOLD    = 400;
    localparam int WATCHDOG_MAX = 20000;
    localparam int DRAIN_CYCLES = 64;
    localparam int CFG_SETTLE   = 8;

    typedef struct {
        logic [ROW_NUM_W-1:0] row_number;
        logic [GRID_W-1:0]    wall_mask;
        logic [GRID_W-1:0]    enclosed_mask;
        logic                 last_row;
    } hole_row_t;

    typedef enum int {
        GRID_NOISE,
        GRID_SPARSE,
        GRID_DENSE,
        GRID_BOX,
        GRID_OPEN,
        GRID_SOLID
    } grid_kind_e;

    // Keeps the grid being loaded and the result rows still owed by the core
    class hole_fill_scoreboard;
        logic [SIZE_W-1:0] size_reg;
        logic [GRID_W-1:0] wall_store [MAX_SIZE_DEF];
        int                rows_loaded;
        hole_row_t         pending_rows [$];
        int                mismatches;

        function new();
            size_reg    = GRID_SIZE_RST;
            rows_loaded = 0;
            mismatches  = 0;
            foreach (wall_store[i])
                wall_store[i] = '0;
        endfunction

        // Zero acts as one, anything past the row count saturates
        function int grid_rows();
            if (size_reg == 0)
                return 1;
            if (size_reg > MAX_SIZE_DEF)
                return MAX_SIZE_DEF;
            return int'(size_reg);
        endfunction

        function logic [GRID_W-1:0] col_mask();
            return GRID_W'((64'd1 << grid_rows()) - 64'd1);
        endfunction

        function void set_grid_size(logic [SIZE_W-1:0] value);
            size_reg    = value;
            rows_loaded = 0;
        endfunction

        function void note_row(logic [GRID_W-1:0] row);
            int                n;
            logic [GRID_W-1:0] cols;
            n    = grid_rows();
            cols = col_mask();
            if (rows_loaded >= n)
                rows_loaded = 0;
            wall_store[rows_loaded] = row & cols;
            rows_loaded++;
            if (rows_loaded == n)
            begin
                rows_loaded = 0;
                flood_enclosed(n, cols);
            end
        endfunction

        // Flood from every open border cell, then queue one result per row
        function void flood_enclosed(int n, logic [GRID_W-1:0] cols);
            logic [GRID_W-1:0] reach [MAX_SIZE_DEF];
            logic [GRID_W-1:0] side_cols;
            logic [GRID_W-1:0] grow;
            bit                changed;
            int                r;
            hole_row_t         res;
            side_cols = cols & (GRID_W'(1) | (GRID_W'(1) << (n - 1)));
            for (r = 0; r < n; r++)
                reach[r] = ((r == 0 || r == n - 1) ? cols : side_cols) & ~wall_store[r] & cols;
            changed = 1'b1;
            while (changed)
            begin
                changed = 1'b0;
                for (r = 0; r < n; r++)
                begin
                    grow = reach[r] | (reach[r] << 1) | (reach[r] >> 1);
                    if (r > 0)
                        grow |= reach[r - 1];
                    if (r + 1 < n)
                        grow |= reach[r + 1];
                    grow &= ~wall_store[r] & cols;
                    if (grow != reach[r])
                    begin
                        reach[r] = grow;
                        changed  = 1'b1;
                    end
                end
            end
            for (r = 0; r < n; r++)
            begin
                res.row_number    = ROW_NUM_W'(r);
                res.wall_mask     = wall_store[r];
                res.enclosed_mask = ~(wall_store[r] | reach[r]) & cols;
                res.last_row      = (r == n - 1);
                pending_rows.push_back(res);
            end
        endfunction

        function void compare_field(string label, logic [GRID_W-1:0] want,
                                    logic [GRID_W-1:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %h actual %h", $time, label, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data, logic last);
            hole_row_t want;
            if (pending_rows.size() == 0)
            begin
                $display("%0t: result item with none expected, expected none actual %h/%b",
                         $time, data, last);
                mismatches++;
                return;
            end
            want = pending_rows.pop_front();
            compare_field("row_number", GRID_W'(want.row_number),
                          GRID_W'(data[ROW_NUM_W-1:0]));
            compare_field("wall_mask", want.wall_mask, data[ROW_NUM_W +: GRID_W]);
            compare_field("enclosed_mask", want.enclosed_mask,
                          data[ROW_NUM_W + GRID_W +: GRID_W]);
            compare_field("pad bits", '0,
                          GRID_W'(data[OUT_DATA_W-1:ROW_NUM_W + 2 * GRID_W]));
            compare_field("last_row", GRID_W'(want.last_row), GRID_W'(last));
        endfunction
    endclass

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_wr_en     = 1'b0;
    logic [SIZE_W-1:0]     cfg_wr_data   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [GRID_W-1:0]     s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    hole_fill_scoreboard sb = new();

    logic [GRID_W-1:0] grid_buf [MAX_SIZE_DEF];
    int                rows_sent      = 0;
    int                stalled_cycles = 0;
    bit                quiet          = 1'b0;
    bit                hold_armed     = 1'b0;

    enclosed_region_flood_fill_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 clk = ~clk;

    // End the run when no item moves on either side for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
        if (stalled_cycles >= WATCHDOG_MAX)
        begin
            $display("tb_enclosed_region_flood_fill_core failed");
            $finish;
        end
    end

    // Check accepted results and pick the next ready level
    initial
    begin : result_sink
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tlast);
            if (hold_armed && m_axis_tvalid)
            begin
                hold_armed = 1'b0;
                hold_left  = LONG_HOLD;
            end
            else if (hold_left == 0 && !quiet && $urandom_range(0, 9) == 0)
                hold_left = $urandom_range(1, 16);
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Offer one row and hold it until accepted; valid stays high on return
    task automatic send_row(input logic [GRID_W-1:0] row, input bit may_idle);
        if (may_idle && !quiet && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= row;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_row(row);
        rows_sent++;
    endtask

    // Write the size only once every owed result has drained
    task automatic write_grid_size(input logic [SIZE_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (sb.pending_rows.size() != 0)
            @(posedge clk);
        repeat (CFG_SETTLE) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_grid_size(value);
    endtask

    // Fill grid_buf with n rows of the given shape; bits past the grid are not masked
    function automatic void make_grid(input grid_kind_e kind, input int n);
        int                top, bot, lft, rgt, r;
        logic [GRID_W-1:0] cols, span, row_bits;
        cols = GRID_W'((64'd1 << n) - 64'd1);
        top  = $urandom_range(0, n - 1);
        bot  = $urandom_range(top, n - 1);
        lft  = $urandom_range(0, n - 1);
        rgt  = $urandom_range(lft, n - 1);
        span = GRID_W'((64'd1 << (rgt + 1)) - (64'd1 << lft));
        for (r = 0; r < n; r++)
        begin
            case (kind)
                GRID_NOISE:  row_bits = $urandom();
                GRID_SPARSE: row_bits = $urandom() & $urandom() & $urandom();
                GRID_DENSE:  row_bits = $urandom() | $urandom();
                GRID_OPEN:   row_bits = ~cols & $urandom();
                GRID_SOLID:  row_bits = '1;
                default:
                begin
                    // sparse noise around a box outline, sometimes with a gap
                    row_bits = $urandom() & $urandom() & $urandom();
                    if (r == top || r == bot)
                        row_bits |= span;
                    else if (r > top && r < bot)
                        row_bits |= (GRID_W'(1) << lft) | (GRID_W'(1) << rgt);
                    if ($urandom_range(0, 4) == 0)
                        row_bits &= ~(GRID_W'(1) << $urandom_range(0, n - 1));
                end
            endcase
            grid_buf[r] = row_bits;
        end
    endfunction

    initial
    begin : stimulus
        int                phase, grids, n, g, r, random_start;
        bit                may_idle;
        logic [SIZE_W-1:0] size_val;
        grid_kind_e        kind;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Partial grid at the reset size, dropped by the size write
        for (r = 0; r < 3; r++)
            send_row($urandom(), 1'b0);
        write_grid_size(6'd3);

        // 3x3 ring with an enclosed center and junk above the grid width
        send_row(32'hFFFF_FFF7, 1'b0);
        send_row(32'hA5A5_A5A5, 1'b0);
        send_row(32'h0000_0007, 1'b0);

        // Size zero acts as one: open cell, then wall
        write_grid_size(6'd0);
        send_row(32'h0000_0000, 1'b0);
        send_row(32'hFFFF_FFFF, 1'b0);

        write_grid_size(6'd1);
        send_row(32'hFFFF_FFFE, 1'b0);

        write_grid_size(6'd2);
        send_row(32'h0000_0000, 1'b0);
        send_row(32'hFFFF_FFFC, 1'b0);

        // Square ring holding a 2x2 hole
        write_grid_size(6'd4);
        send_row(32'h0000_000F, 1'b0);
        send_row(32'h0000_0009, 1'b0);
        send_row(32'h0000_0009, 1'b0);
        send_row(32'h0000_000F, 1'b0);

        write_grid_size(6'd5);
        for (r = 0; r < 5; r++)
            send_row(32'hFFFF_FFFF, 1'b0);

        // Random grids at random sizes, mostly small
        random_start = rows_sent;
        phase        = 0;
        while (rows_sent - random_start < RANDOM_ROWS)
        begin
            case ($urandom_range(0, 15))
                0:          size_val = SIZE_W'($urandom_range(0, 1));
                9, 10, 11:  size_val = SIZE_W'($urandom_range(9, 20));
                12:         size_val = SIZE_W'($urandom_range(21, 31));
                13:         size_val = 6'd32;
                14:         size_val = SIZE_W'($urandom_range(33, 63));
                default:    size_val = SIZE_W'($urandom_range(2, 8));
            endcase
            if (phase == 0)
                size_val = 6'd6;
            else if (phase == 1)
                size_val = 6'd63;
            else if (phase == 2)
                size_val = 6'd32;
            write_grid_size(size_val);
            n = sb.grid_rows();
            if (phase == 0)
            begin
                grids      = 3;
                hold_armed = 1'b1;
            end
            else if (n <= 8)
                grids = $urandom_range(1, 5);
            else if (n <= 20)
                grids = $urandom_range(1, 2);
            else
                grids = 1;

            for (g = 0; g < grids; g++)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2: kind = GRID_BOX;
                    5:       kind = GRID_SPARSE;
                    6:       kind = GRID_DENSE;
                    7:       kind = GRID_OPEN;
                    8:       kind = GRID_SOLID;
                    default: kind = GRID_NOISE;
                endcase
                make_grid(kind, n);
                may_idle = $urandom_range(0, 1);
                for (r = 0; r < n; r++)
                    send_row(grid_buf[r], may_idle);
                if (rows_sent - random_start > QUIET_AFTER)
                    quiet = 1'b1;
            end

            // Now and then leave a grid unfinished before the next size write
            if (n > 1 && $urandom_range(0, 5) == 0)
            begin
                for (r = $urandom_range(1, n - 1); r > 0; r--)
                    send_row($urandom(), 1'b1);
            end
            phase++;
        end
        s_axis_tvalid <= 1'b0;

        // Drain, then give the core time to show any stray result
        while (sb.pending_rows.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
            $display("tb_enclosed_region_flood_fill_core passed");
        else
            $display("tb_enclosed_region_flood_fill_core failed");
        $finish;
    end

endmodule
